// File: design/sprle_pkg.sv
// Package for the sprite run-length decoder: microcode ROM, control word types,
// stream codes and the two-bit restoring divider step.
// No dependencies.
package sprle_pkg;

    localparam int          StepW         = 4;
    localparam int          DivSteps      = 6;        // 12-bit dividend, two bits per step
    localparam logic [7:0]  CODE_RUN      = 8'h00;
    localparam logic [7:0]  CODE_ROW_SKIP = 8'h40;
    localparam logic [7:0]  ALPHA_SCALE   = 8'h11;
    localparam logic [10:0] ROW_MAX       = 11'h7FF;
    localparam logic [19:0] ADDR_MAX      = 20'hFFFFF;
    localparam logic [10:0] REG_RESET     = 11'd64;

    // register map (word index taken from paddr[2])
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // microprogram addresses
    localparam logic [StepW-1:0] S_FETCH    = 4'd0;
    localparam logic [StepW-1:0] S_DISPATCH = 4'd1;
    localparam logic [StepW-1:0] S_HEADER   = 4'd2;
    localparam logic [StepW-1:0] S_HDIV     = 4'd3;
    localparam logic [StepW-1:0] S_HWRAP    = 4'd4;
    localparam logic [StepW-1:0] S_PCHECK   = 4'd5;
    localparam logic [StepW-1:0] S_PDIV     = 4'd6;
    localparam logic [StepW-1:0] S_PWRAP    = 4'd7;
    localparam logic [StepW-1:0] S_MUL      = 4'd8;
    localparam logic [StepW-1:0] S_EMIT     = 4'd9;
    localparam logic [StepW-1:0] S_ADVANCE  = 4'd10;
    localparam logic [StepW-1:0] S_FINISH   = 4'd11;

    typedef enum logic [3:0] {
        U_NOP,
        U_FETCH,
        U_HEADER,
        U_DIV_LOAD,
        U_DIV_STEP,
        U_WRAP,
        U_MUL,
        U_EMIT,
        U_ADVANCE,
        U_FINISH
    } uop_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_RUN_ACTIVE,
        C_NOT_COLSKIP,
        C_DIV_MORE,
        C_COL_IN_RANGE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        uop_t             op;
        cond_t            cond;
        logic [StepW-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic [10:0] rem;
        logic [11:0] quo;   // dividend shifts out at the top, quotient in at the bottom
    } div_state_t;

    function automatic ucode_t ucode_rom(logic [StepW-1:0] step);
        ucode_t w;
        case (step)
            S_FETCH:    w = '{U_FETCH,    C_NO_INPUT,     S_FETCH};
            S_DISPATCH: w = '{U_NOP,      C_RUN_ACTIVE,   S_PCHECK};
            S_HEADER:   w = '{U_HEADER,   C_NOT_COLSKIP,  S_FINISH};
            S_HDIV:     w = '{U_DIV_STEP, C_DIV_MORE,     S_HDIV};
            S_HWRAP:    w = '{U_WRAP,     C_ALWAYS,       S_FINISH};
            S_PCHECK:   w = '{U_DIV_LOAD, C_COL_IN_RANGE, S_MUL};
            S_PDIV:     w = '{U_DIV_STEP, C_DIV_MORE,     S_PDIV};
            S_PWRAP:    w = '{U_WRAP,     C_NEVER,        S_FETCH};
            S_MUL:      w = '{U_MUL,      C_NEVER,        S_FETCH};
            S_EMIT:     w = '{U_EMIT,     C_OUT_BUSY,     S_EMIT};
            S_ADVANCE:  w = '{U_ADVANCE,  C_NEVER,        S_FETCH};
            S_FINISH:   w = '{U_FINISH,   C_ALWAYS,       S_FETCH};
            default:    w = '{U_NOP,      C_ALWAYS,       S_FETCH};
        endcase
        return w;
    endfunction

    // two restoring division steps
    function automatic div_state_t div_step2(div_state_t s, logic [10:0] d);
        div_state_t r;
        logic [11:0] t;
        r = s;
        for (int i = 0; i < 2; i++)
        begin
            t = {r.rem, r.quo[11]};
            if (t >= {1'b0, d})
            begin
                r.rem = 11'(t - {1'b0, d});
                r.quo = {r.quo[10:0], 1'b1};
            end
            else
            begin
                r.rem = t[10:0];
                r.quo = {r.quo[10:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic [10:0] row_sat(logic [12:0] v);
        return (v > {2'b00, ROW_MAX}) ? ROW_MAX : v[10:0];
    endfunction

endpackage

// File: design/sprite_rle_16bit_alpha_decoder.sv
// Sprite run-length decoder, 16-bit pixel words with 4-bit alpha: top level.
// Holds the microcode sequencer, datapath, APB registers and output register.
// Depends on sprle_pkg.
//
// Usage: stream words enter on s_tdata (first stream byte in bits 7:0) with
// s_tlast on the final word of a sprite; every pixel word gives one output
// transaction carrying its linear address, palette index and alpha, with
// m_tuser flagging rows at or past the image height. Header words give no
// output. Width and height are written over APB (width at 0x0, height at 0x4);
// the user must write them only while the block is idle; the block itself does
// not enforce this. One word is in flight at a time. A column-skip header, and a
// pixel word whose column is not below the width, pass through the shared
// column-wrap divider, which retires two quotient bits per cycle over a 12-bit
// dividend. The output stage holds one result; a pixel word waits at its emit
// step while the previous result is still untaken.
module sprite_rle_16bit_alpha_decoder #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] data_word
    input  logic        s_tlast,    // last_word
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [19:0] pixel_address, [27:20] color_index,
                                    // [35:28] alpha, [39:36] zero
    output logic        m_tuser,    // outside_image
    // APB
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sprle_pkg::*;

    localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
    localparam logic [12:0] MaxH = 13'(MAX_HEIGHT);

    // configuration
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [10:0] eff_w;
    logic [10:0] eff_h;

    // sequencer
    logic [StepW-1:0] step_reg, step_next;
    ucode_t           uc;
    logic             cond_true;

    // state
    logic [10:0] column_reg, column_next;
    logic [10:0] row_reg, row_next;
    logic [7:0]  pixels_left_reg, pixels_left_next;
    logic [2:0]  div_cnt_reg, div_cnt_next;

    // payload
    logic [15:0] word_reg;
    logic        last_reg;
    div_state_t  div_reg, div_next;
    logic [21:0] prod_reg;

    logic        out_valid_reg, out_valid_next;
    logic [19:0] addr_reg;
    logic [7:0]  color_reg;
    logic [7:0]  alpha_reg;
    logic        outside_reg;

    logic [7:0]  hdr_code;
    logic [7:0]  hdr_val;
    logic        out_busy;
    logic        emit_fire;
    logic [22:0] addr_sum;
    logic [11:0] col_inc;

    // ---------------------------------------------------------------- APB
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEIGHT) ? {21'd0, height_reg} : {21'd0, width_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= REG_RESET;
            height_reg <= REG_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_WIDTH)
                width_reg <= pwdata[10:0];
            else
                height_reg <= pwdata[10:0];
        end
    end

    // zero width behaves as one; both clamp to their maxima
    always_comb
    begin
        if (width_reg == 11'd0)
            eff_w = 11'd1;
        else if ({2'b00, width_reg} > MaxW)
            eff_w = MaxW[10:0];
        else
            eff_w = width_reg;
        eff_h = ({2'b00, height_reg} > MaxH) ? MaxH[10:0] : height_reg;
    end

    // ---------------------------------------------------------- sequencer
    assign uc        = ucode_rom(step_reg);
    assign hdr_code  = word_reg[15:8];
    assign hdr_val   = word_reg[7:0];
    assign out_busy  = out_valid_reg && !m_tready;
    assign emit_fire = (uc.op == U_EMIT) && !out_busy;
    assign s_tready  = (uc.op == U_FETCH);

    always_comb
    begin
        case (uc.cond)
            C_NEVER:        cond_true = 1'b0;
            C_ALWAYS:       cond_true = 1'b1;
            C_NO_INPUT:     cond_true = !s_tvalid;
            C_RUN_ACTIVE:   cond_true = (pixels_left_reg != 8'd0);
            C_NOT_COLSKIP:  cond_true = (hdr_code == CODE_RUN) || (hdr_code == CODE_ROW_SKIP);
            C_DIV_MORE:     cond_true = (div_cnt_reg != 3'd1);
            C_COL_IN_RANGE: cond_true = (column_reg < eff_w);
            C_OUT_BUSY:     cond_true = out_busy;
            default:        cond_true = 1'b0;
        endcase
        step_next = cond_true ? uc.target : StepW'(step_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= S_FETCH;
        else
            step_reg <= step_next;
    end

    // ----------------------------------------------------------- datapath
    assign addr_sum = {1'b0, prod_reg} + {12'd0, column_reg};
    assign col_inc  = {1'b0, column_reg} + 12'd1;

    always_comb
    begin
        column_next      = column_reg;
        row_next         = row_reg;
        pixels_left_next = pixels_left_reg;
        div_cnt_next     = div_cnt_reg;
        div_next         = div_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        case (uc.op)
            U_HEADER:
            begin
                if (hdr_code == CODE_RUN)
                    pixels_left_next = hdr_val;
                else if (hdr_code == CODE_ROW_SKIP)
                    row_next = row_sat({2'b00, row_reg} + {5'd0, hdr_val});
                else
                begin
                    // column skip: wrap column + count by the width
                    div_next.rem = 11'd0;
                    div_next.quo = {1'b0, column_reg} + {4'd0, hdr_val};
                    div_cnt_next = 3'(DivSteps);
                end
            end
            U_DIV_LOAD:
            begin
                div_next.rem = 11'd0;
                div_next.quo = {1'b0, column_reg};
                div_cnt_next = 3'(DivSteps);
            end
            U_DIV_STEP:
            begin
                div_next     = div_step2(div_reg, eff_w);
                div_cnt_next = div_cnt_reg - 3'd1;
            end
            U_WRAP:
            begin
                row_next    = row_sat({2'b00, row_reg} + {1'b0, div_reg.quo});
                column_next = div_reg.rem;
            end
            U_EMIT:
            begin
                if (emit_fire)
                    out_valid_next = 1'b1;
            end
            U_ADVANCE:
            begin
                // column is below the width here, so the wrap is at most one row
                if (col_inc >= {1'b0, eff_w})
                begin
                    column_next = 11'd0;
                    row_next    = row_sat({2'b00, row_reg} + 13'd1);
                end
                else
                    column_next = col_inc[10:0];
                pixels_left_next = pixels_left_reg - 8'd1;
            end
            U_FINISH:
            begin
                if (last_reg)
                begin
                    column_next      = 11'd0;
                    row_next         = 11'd0;
                    pixels_left_next = 8'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg      <= 11'd0;
            row_reg         <= 11'd0;
            pixels_left_reg <= 8'd0;
            div_cnt_reg     <= 3'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            column_reg      <= column_next;
            row_reg         <= row_next;
            pixels_left_reg <= pixels_left_next;
            div_cnt_reg     <= div_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        if (s_tvalid && s_tready)
        begin
            word_reg <= s_tdata;
            last_reg <= s_tlast;
        end
        if (uc.op == U_MUL)
            prod_reg <= row_reg * eff_w;
        if (emit_fire)
        begin
            addr_reg    <= (addr_sum > {3'd0, ADDR_MAX}) ? ADDR_MAX : addr_sum[19:0];
            color_reg   <= word_reg[8:1];
            alpha_reg   <= 8'({4'd0, word_reg[12:9]} * ALPHA_SCALE);
            outside_reg <= ({2'b00, row_reg} >= {2'b00, eff_h});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, alpha_reg, color_reg, addr_reg};
    assign m_tuser  = outside_reg;

    // --------------------------------------------------------- assertions
    a_div_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        (uc.op == U_DIV_STEP) |-> (div_cnt_reg != 3'd0))
        else $error("divider step with no steps left");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(uc.op == U_EMIT))
        else $error("result raised outside the emit step");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (step_reg == S_DISPATCH))
        else $error("accepted word not dispatched");

    a_emit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (uc.op == U_EMIT) |-> (pixels_left_reg != 8'd0))
        else $error("pixel emitted with no run pending");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("pending result overwritten");

endmodule
